// ===== hdl/gnpsd_pkg.sv =====
// Shared constants and types for the greedy nearest-point set distance core.
package gnpsd_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 16;
  localparam int MAG_W      = COORD_W;          // |a - b| of two coordinates
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSQ_W      = SQ_W + 1;         // dx^2 + dy^2
  localparam int SUM_W      = 44;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEP_W     = $clog2(ROOT_W);

  localparam int DIST_W     = 22;
  localparam int PL_W       = 9;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FETCH_LAST,
    S_WRITE_LAST,
    S_SQRT_INIT,
    S_SQRT,
    S_EMIT
  } state_e;

endpackage

// ===== hdl/greedy_nearest_point_set_distance_core.sv =====
// Greedy nearest-point set distance core: point store, nearest search and root unit.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per handshake:
//   opcode_i = load appends (point_x_i, point_y_i) to the reference store,
//   opcode_i = query matches the point against the nearest stored point,
//   removes it (last entry moves into its slot) and adds the squared
//   distance to a saturating 44-bit sum. A query with last_query_i emits
//   floor(sqrt(sum)), the points still stored and the overflow flag on the
//   output channel (out_valid_o / out_ready_i), then clears the batch.
//   Sequence: a load is written in the idle state. A query on N stored points
//   sweeps the point store's single read port one entry per cycle into the
//   distance/compare pipeline, drains it, then moves the last entry into the
//   matched slot; on an empty store it stays idle unless last. A last query
//   runs a digit-by-digit square root, one result bit per cycle, then emits.
//   in_ready_o is high only while the sequencer is idle.
//   Stall: the result sits in an output register; new items are taken while
//   it waits, and only a later emit holds until that result is taken.
//   Reset: point count, sum, overflow flag and output valid clear; the store
//   holds no valid bits since only entries below the count are ever read.
module greedy_nearest_point_set_distance_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic signed [gnpsd_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [gnpsd_pkg::COORD_W-1:0] point_y_i,
  input  logic                          last_query_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gnpsd_pkg::DIST_W-1:0]  distance_o,
  output logic [gnpsd_pkg::PL_W-1:0]    points_left_o,
  output logic                          load_overflow_o
);
  import gnpsd_pkg::*;

  // Sequencer and batch state
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   ovf_q, ovf_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]       cnt_last;

  // Latched query
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic                   last_q;
  logic                   capture;

  // Point store: {x, y} per entry, one write and one registered read port
  logic [2*COORD_W-1:0]   mem [MAX_POINTS];
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [2*COORD_W-1:0]   mem_wdata, rdata_q;

  // Distance pipeline
  logic                   issue;
  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic [IDX_W-1:0]       s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [COORD_W:0] dx, dy;
  logic [MAG_W-1:0]       ax_q, ay_q;
  logic [SQ_W-1:0]        sqx_q, sqy_q;
  logic [DSQ_W-1:0]       dsq;
  logic [DSQ_W-1:0]       best_d_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_sat;

  // Square root unit
  logic                   sqrt_init, sqrt_step;
  logic [SUM_W-1:0]       rad_q;
  logic [REM_W-1:0]       rem_q;
  logic [ROOT_W-1:0]      root_q;
  logic [STEP_W-1:0]      step_q;
  logic [REM_W+1:0]       rem_shift, trial, rem_diff;
  logic                   take;

  // Output register
  logic                   emit;
  logic                   out_valid_q;
  logic [DIST_W-1:0]      dist_q;
  logic [PL_W-1:0]        left_q;
  logic                   lovf_q;

  assign cnt_last = count_q - CNT_W'(1);

  // Saturating accumulate of the matched distance
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(best_d_q);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  // One radicand digit pair per step
  assign rem_shift = {rem_q, rad_q[SUM_W-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign take      = (rem_shift >= trial);
  assign rem_diff  = rem_shift - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      sum_q    <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      ovf_q    <= ovf_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    sum_d     = sum_q;
    ovf_d     = ovf_q;
    rd_idx_d  = rd_idx_q;
    in_ready_o = 1'b0;
    capture   = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = {point_x_i, point_y_i};
    mem_raddr = rd_idx_q[IDX_W-1:0];
    sqrt_init = 1'b0;
    sqrt_step = 1'b0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OP_LOAD) begin
            // Append, or drop and flag when the store is full
            if (count_q < CNT_W'(MAX_POINTS)) begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            capture  = 1'b1;
            rd_idx_d = '0;
            if (count_q != '0) begin
              state_d = S_SCAN;
            end else if (last_query_i) begin
              state_d = S_SQRT_INIT;
            end
          end
        end
      end
      S_SCAN: begin
        // Sweep stored entries into the distance pipeline
        issue    = 1'b1;
        mem_re   = 1'b1;
        rd_idx_d = rd_idx_q + CNT_W'(1);
        if (rd_idx_q == cnt_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q) begin
          state_d = S_FETCH_LAST;
        end
      end
      S_FETCH_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_last[IDX_W-1:0];
        state_d   = S_WRITE_LAST;
      end
      S_WRITE_LAST: begin
        // Move the last entry into the matched slot
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = rdata_q;
        sum_d     = sum_sat;
        count_d   = cnt_last;
        state_d   = last_q ? S_SQRT_INIT : S_IDLE;
      end
      S_SQRT_INIT: begin
        sqrt_init = 1'b1;
        state_d   = S_SQRT;
      end
      S_SQRT: begin
        sqrt_step = 1'b1;
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Point store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Query latch
  always_ff @(posedge clk_i) begin
    if (capture) begin
      qx_q   <= point_x_i;
      qy_q   <= point_y_i;
      last_q <= last_query_i;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  assign dx  = {qx_q[COORD_W-1], qx_q} - {rdata_q[2*COORD_W-1], rdata_q[2*COORD_W-1:COORD_W]};
  assign dy  = {qy_q[COORD_W-1], qy_q} - {rdata_q[COORD_W-1], rdata_q[COORD_W-1:0]};
  assign dsq = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Distance stages: magnitudes, squares, sum and compare
  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_idx_q[IDX_W-1:0];
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    ax_q     <= dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
    ay_q     <= dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
    sqx_q    <= ax_q * ax_q;
    sqy_q    <= ay_q * ay_q;
    // Keep the first strict minimum
    if (s3_v_q && ((s3_idx_q == '0) || (dsq < best_d_q))) begin
      best_d_q   <= dsq;
      best_idx_q <= s3_idx_q;
    end
  end

  // Square root unit
  always_ff @(posedge clk_i) begin
    if (sqrt_init) begin
      rad_q  <= sum_q;
      rem_q  <= '0;
      root_q <= '0;
      step_q <= '0;
    end else if (sqrt_step) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= take ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], take};
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dist_q <= DIST_W'(root_q);
      left_q <= PL_W'(count_q);
      lovf_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign distance_o      = dist_q;
  assign points_left_o   = left_q;
  assign load_overflow_o = lovf_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0) && (rd_idx_q < count_q))
    else $error("scan past stored points");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(s1_v_q || s2_v_q || s3_v_q))
    else $error("distance pipeline busy while idle");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE_LAST) |-> (CNT_W'(best_idx_q) < count_q))
    else $error("matched index outside store");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && (count_q == '0) && (sum_q == '0) && !ovf_q)
    else $error("batch not cleared on emit");

endmodule

// ===== tb/sv/tb_greedy_nearest_point_set_distance_core.sv =====
// Testbench for the greedy nearest-point set distance core: queued stimulus, scoreboard, watchdog.
module tb_greedy_nearest_point_set_distance_core;
  import gnpsd_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int CORNER_PAIRS   = 20;
  // Longest quiet stretch of a correct run: long input gap, full scan, root, long output stall.
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  typedef struct {
    opcode_e                    op;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       last;
  } point_item_t;

  typedef struct {
    logic [DIST_W-1:0]  distance;
    logic [PL_W-1:0]    points_left;
    logic               load_overflow;
  } distance_report_t;

  // DUT ports, known from time zero
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic                       opcode_i        = 1'b0;
  logic signed [COORD_W-1:0]  point_x_i       = '0;
  logic signed [COORD_W-1:0]  point_y_i       = '0;
  logic                       last_query_i    = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic [DIST_W-1:0]          distance_o;
  logic [PL_W-1:0]            points_left_o;
  logic                       load_overflow_o;

  greedy_nearest_point_set_distance_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .last_query_i    (last_query_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .distance_o      (distance_o),
    .points_left_o   (points_left_o),
    .load_overflow_o (load_overflow_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: point store, count, saturating sum, drop flag
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0]  stored_x [MAX_POINTS];
  logic signed [COORD_W-1:0]  stored_y [MAX_POINTS];
  int                         stored_count = 0;
  longint unsigned            sq_sum       = 0;
  logic                       drop_seen    = 1'b0;

  point_item_t       pending_items[$];
  distance_report_t  expected_reports[$];

  int n_loads     = 0;
  int n_queries   = 0;
  int n_drops     = 0;
  int n_empty_q   = 0;
  int n_saturated = 0;
  int n_reports   = 0;
  int mismatches  = 0;

  function automatic longint unsigned sq_gap(logic signed [COORD_W-1:0] ax,
                                             logic signed [COORD_W-1:0] ay,
                                             logic signed [COORD_W-1:0] bx,
                                             logic signed [COORD_W-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  // Floor square root, one result bit per step
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Apply one accepted item to the shadow state; a last query queues a report.
  function automatic void match_and_accumulate(point_item_t it);
    int               best_i;
    longint unsigned  best_d;
    longint unsigned  d;
    longint unsigned  wide;
    distance_report_t rep;
    if (it.op == OP_LOAD) begin
      n_loads++;
      if (stored_count < MAX_POINTS) begin
        stored_x[stored_count] = it.x;
        stored_y[stored_count] = it.y;
        stored_count++;
      end else begin
        drop_seen = 1'b1;
        n_drops++;
      end
      return;
    end
    n_queries++;
    if (stored_count > 0) begin
      best_i = 0;
      best_d = sq_gap(it.x, it.y, stored_x[0], stored_y[0]);
      for (int i = 1; i < stored_count; i++) begin
        d = sq_gap(it.x, it.y, stored_x[i], stored_y[i]);
        // strict compare keeps the lowest index on a tie
        if (d < best_d) begin
          best_d = d;
          best_i = i;
        end
      end
      wide = sq_sum + best_d;
      sq_sum = (wide > SUM_LIMIT) ? SUM_LIMIT : wide;
      stored_count--;
      stored_x[best_i] = stored_x[stored_count];
      stored_y[best_i] = stored_y[stored_count];
    end else begin
      n_empty_q++;
    end
    if (!it.last) return;
    if (sq_sum == SUM_LIMIT) n_saturated++;
    rep.distance      = DIST_W'(floor_sqrt(sq_sum));
    rep.points_left   = PL_W'(stored_count);
    rep.load_overflow = drop_seen;
    expected_reports.insert(expected_reports.size(), rep);
    stored_count = 0;
    sq_sum       = 0;
    drop_seen    = 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_item(opcode_e op, int x, int y, logic last);
    point_item_t it;
    it.op   = op;
    it.x    = COORD_W'(x);
    it.y    = COORD_W'(y);
    it.last = last;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Grid coordinates give frequent ties; wide ones exercise every bit.
  function automatic int pick_coord(bit on_grid);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return -32768;
        1:       return 32767;
        2:       return 0;
        default: return -1;
      endcase
    end
    if (on_grid || r < 3) return 16 * ($urandom_range(0, 6) - 3);
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic build_directed();
    // Query on an empty store, marked last: still reports
    add_item(OP_QUERY, 0, 0, 1'b1);
    // Last flag on a load is ignored; extreme corners
    add_item(OP_LOAD, -32768, -32768, 1'b1);
    add_item(OP_LOAD, 32767, 32767, 1'b0);
    add_item(OP_QUERY, -32768, -32768, 1'b0);
    add_item(OP_QUERY, -32768, 32767, 1'b1);
    // Tie: lowest index wins, the follow-up query tells which one went
    add_item(OP_LOAD, 0, 16, 1'b0);
    add_item(OP_LOAD, 0, -16, 1'b0);
    add_item(OP_QUERY, 0, 0, 1'b0);
    add_item(OP_QUERY, 0, 16, 1'b1);
    // Three-way tie, then swap-remove order matters
    add_item(OP_LOAD, 0, 16, 1'b0);
    add_item(OP_LOAD, 16, 0, 1'b0);
    add_item(OP_LOAD, 0, -16, 1'b0);
    add_item(OP_QUERY, 0, 0, 1'b0);
    add_item(OP_QUERY, 0, 0, 1'b0);
    add_item(OP_QUERY, 16, 16, 1'b1);
    // Queries past an empty store add nothing
    add_item(OP_LOAD, 5, 7, 1'b0);
    add_item(OP_QUERY, 1, 2, 1'b0);
    add_item(OP_QUERY, 100, 100, 1'b0);
    add_item(OP_QUERY, -1, -1, 1'b1);
    // Points left over at the report
    add_item(OP_LOAD, 32767, -32768, 1'b0);
    add_item(OP_LOAD, -32768, 32767, 1'b0);
    add_item(OP_LOAD, -1, 0, 1'b0);
    add_item(OP_QUERY, 0, -1, 1'b1);
  endtask

  task automatic build_random();
    int  made;
    int  loads;
    int  queries;
    bit  on_grid;
    // Full store with dropped loads
    for (int i = 0; i < MAX_POINTS + 3; i++)
      add_item(OP_LOAD, pick_coord(1'b0), pick_coord(1'b0), 1'($urandom_range(0, 1)));
    for (int i = 0; i < 5; i++) add_item(OP_QUERY, pick_coord(1'b0), pick_coord(1'b0), i == 4);
    made = MAX_POINTS + 8;
    // Full store drained, then queries on the empty store
    for (int i = 0; i < MAX_POINTS; i++) add_item(OP_LOAD, pick_coord(1'b1), pick_coord(1'b1), 1'b0);
    for (int i = 0; i < MAX_POINTS + 3; i++)
      add_item(OP_QUERY, pick_coord(1'b1), pick_coord(1'b1), i == MAX_POINTS + 2);
    made += 2 * MAX_POINTS + 3;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any opcode, any flag
        for (int i = 0; i < 8; i++)
          add_item(opcode_e'($urandom_range(0, 1)), pick_coord(1'b0), pick_coord(1'b0),
                   1'($urandom_range(0, 1)));
        made += 8;
      end else begin
        on_grid = ($urandom_range(0, 2) == 0);
        loads   = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        queries = loads + $urandom_range(0, 4) - 2;
        if (queries < 1) queries = 1;
        for (int i = 0; i < loads; i++) add_item(OP_LOAD, pick_coord(on_grid), pick_coord(on_grid), 1'b0);
        for (int i = 0; i < queries; i++)
          add_item(OP_QUERY, pick_coord(on_grid), pick_coord(on_grid), i == queries - 1);
        made += loads + queries;
      end
    end
    // Opposite corners back to back give the largest distances
    for (int i = 0; i < CORNER_PAIRS; i++) begin
      if (i % 2 == 0) begin
        add_item(OP_LOAD, -32768, -32768, 1'b0);
        add_item(OP_QUERY, 32767, 32767, 1'b0);
      end else begin
        add_item(OP_LOAD, 32767, -32768, 1'b0);
        add_item(OP_QUERY, -32768, 32767, 1'b0);
      end
    end
    add_item(OP_QUERY, 0, 0, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued items, hold each until accepted, idle at random
  // ---------------------------------------------------------------------
  point_item_t cur_item;
  int          in_gap  = 0;
  bit          in_calm = 1'b0;

  always @(posedge clk_i) begin
    bit holding;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        match_and_accumulate(cur_item);
        holding = 1'b0;
        in_gap  = pick_gap(in_calm);
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      end
      if (!holding) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item     = pending_items.pop_front();
          in_valid_i   <= 1'b1;
          opcode_i     <= cur_item.op;
          point_x_i    <= cur_item.x;
          point_y_i    <= cur_item.y;
          last_query_i <= cur_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: runs of ready and stalls of random length
  int out_hold = 0;
  bit out_calm = 1'b0;

  always @(posedge clk_i) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (out_calm || r < 50) begin
        out_ready_i <= 1'b1;
        out_hold = $urandom_range(0, 20);
      end else begin
        out_ready_i <= 1'b0;
        if (r < 90)      out_hold = $urandom_range(0, 4);
        else if (r < 98) out_hold = $urandom_range(5, 30);
        else             out_hold = $urandom_range(60, 200);
      end
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
    end
  end

  // Monitor: compare each taken result with the oldest expected report
  always @(posedge clk_i) begin
    distance_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: distance %0d points_left %0d load_overflow %0d",
               distance_o, points_left_o, load_overflow_o);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        n_reports++;
        if (distance_o !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance_o);
          mismatches++;
        end
        if (points_left_o !== want.points_left) begin
          $error("points_left: expected %0d, got %0d", want.points_left, points_left_o);
          mismatches++;
        end
        if (load_overflow_o !== want.load_overflow) begin
          $error("load_overflow: expected %0d, got %0d", want.load_overflow, load_overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a handshake", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Sequence: build stimulus, reset, wait for drain, report
  initial begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      stored_x[i] = '0;
      stored_y[i] = '0;
    end
    build_directed();
    build_random();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_reports.size() > 0)
      @(negedge clk_i);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d loads (%0d dropped on a full store) and %0d queries (%0d on empty store).",
             n_loads, n_drops, n_queries, n_empty_q);
    $display("Checked %0d batch reports, %0d with a saturated sum; %0d mismatches.",
             n_reports, n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== greedy_nearest_point_set_distance_core.f =====
hdl/gnpsd_pkg.sv
hdl/greedy_nearest_point_set_distance_core.sv
tb/sv/tb_greedy_nearest_point_set_distance_core.sv
